FILE: rtl/tohp_pkg.sv
// Shared types, constants and the glyph table of the text overlay horizon pixel core.
`timescale 1ns / 1ps
`default_nettype none

package tohp_pkg;

    // Screen geometry
    localparam int SCREEN_W = 128;
    localparam int SCREEN_H = 128;

    // Text store geometry
    localparam int TEXT_ROWS  = 7;
    localparam int TEXT_COLS  = 6;
    localparam int ROW_PITCH  = 8;    // pixel rows per text row
    localparam int CELL_PITCH = 5;    // pixel columns per cell, gap included
    localparam int GLYPH_H    = 5;
    localparam int GLYPH_W    = 4;
    localparam int CODE_W     = 4;
    localparam int CIDX_W     = 2;
    localparam int CELL_W     = CODE_W + CIDX_W;
    localparam int ROW_W      = TEXT_COLS * CELL_W;
    localparam int ROW_IDX_W  = $clog2(TEXT_ROWS);
    localparam int COL_IDX_W  = $clog2(TEXT_COLS);

    // Ports and configuration
    localparam int COLOUR_W   = 16;
    localparam int VALUE_W    = 16;
    localparam int COORD_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 2;

    // Reticle: V of half width RET_HALF, depth RET_PEAK at the center
    localparam int RET_HALF = 8;
    localparam int RET_PEAK = 3;

    // Number formatting
    localparam int MAG_W      = 14;     // magnitude after wrap, below 10000
    localparam int MAG_MOD    = 10000;
    localparam int RADIX      = 10;
    localparam int RECIP10    = 6554;   // ceil(2^16 / 10), exact below 10000
    localparam int RECIP_SHIFT = 16;

    // Character codes
    localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
    localparam logic [CODE_W-1:0] CODE_DOT   = 4'd11;
    localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;
    localparam logic [CIDX_W-1:0] CIDX_DOT   = 2'd0;

    // Text colour indexes
    localparam logic [CIDX_W-1:0] CIDX_ZERO  = 2'd0;
    localparam logic [CIDX_W-1:0] CIDX_ONE   = 2'd1;
    localparam logic [CIDX_W-1:0] CIDX_TWO   = 2'd2;
    localparam logic [CIDX_W-1:0] CIDX_THREE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SKY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETICLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT0   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT3   = 3'd6;

    // Register reset values
    localparam logic [COLOUR_W-1:0] RST_SKY     = 16'h733F;
    localparam logic [COLOUR_W-1:0] RST_GROUND  = 16'h63C5;
    localparam logic [COLOUR_W-1:0] RST_RETICLE = 16'hFFE0;
    localparam logic [COLOUR_W-1:0] RST_TEXT0   = 16'hFFFF;
    localparam logic [COLOUR_W-1:0] RST_TEXT1   = 16'h07FF;
    localparam logic [COLOUR_W-1:0] RST_TEXT2   = 16'hFFE0;
    localparam logic [COLOUR_W-1:0] RST_TEXT3   = 16'hF800;

    typedef struct packed {
        logic [COLOUR_W-1:0] sky;
        logic [COLOUR_W-1:0] ground;
        logic [COLOUR_W-1:0] reticle;
        logic [COLOUR_W-1:0] text0;
        logic [COLOUR_W-1:0] text1;
        logic [COLOUR_W-1:0] text2;
        logic [COLOUR_W-1:0] text3;
    } palette_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic                 is_pixel;
        logic                 row_ok;     // write targets an existing row
        logic [ROW_IDX_W-1:0] row;        // text row written or covered
        logic [CIDX_W-1:0]    cidx;
        logic                 neg;
        logic [MAG_W-1:0]     mag;
        logic                 sky;
        logic                 lit_pos;    // pixel sits on a glyph dot position
        logic [COL_IDX_W-1:0] col;
        logic [2:0]           glyph_r;
        logic [1:0]           glyph_s;
        logic                 reticle;
    } work_t;

    // Glyph columns of one code, slice s at bits [5s +: 5], bit r = pixel row r
    function automatic logic [GLYPH_W*GLYPH_H-1:0] glyph_slices(
        input logic [CODE_W-1:0] code
    );
        logic [GLYPH_W*GLYPH_H-1:0] g;
        begin
            unique case (code)
                4'd0:       g = {5'h0E, 5'h11, 5'h11, 5'h0E};
                4'd1:       g = {5'h00, 5'h10, 5'h1F, 5'h12};
                4'd2:       g = {5'h12, 5'h15, 5'h19, 5'h12};
                4'd3:       g = {5'h0A, 5'h15, 5'h11, 5'h11};
                4'd4:       g = {5'h04, 5'h1F, 5'h04, 5'h07};
                4'd5:       g = {5'h09, 5'h15, 5'h15, 5'h17};
                4'd6:       g = {5'h09, 5'h15, 5'h15, 5'h0E};
                4'd7:       g = {5'h03, 5'h05, 5'h09, 5'h11};
                4'd8:       g = {5'h0A, 5'h15, 5'h15, 5'h0A};
                4'd9:       g = {5'h0E, 5'h15, 5'h05, 5'h02};
                CODE_MINUS: g = {5'h04, 5'h04, 5'h04, 5'h04};
                CODE_DOT:   g = {5'h00, 5'h10, 5'h10, 5'h00};
                default:    g = '0;
            endcase
            return g;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tohp_if.sv
// Valid/ready channel interfaces for input items and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface tohp_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [2:0]         text_row;
    logic [1:0]         text_colour;
    logic signed [15:0] value_hundredths;
    logic [6:0]         pixel_x;
    logic [6:0]         pixel_y;
    logic signed [15:0] horizon_y;

    modport source (
        output valid, kind, text_row, text_colour, value_hundredths,
               pixel_x, pixel_y, horizon_y,
        input  ready
    );
    modport sink (
        input  valid, kind, text_row, text_colour, value_hundredths,
               pixel_x, pixel_y, horizon_y,
        output ready
    );
endinterface

interface tohp_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_colour;

    modport source (output valid, pixel_colour, input ready);
    modport sink   (input valid, pixel_colour, output ready);
endinterface

`default_nettype wire

FILE: rtl/tohp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tohp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/tohp_front.sv
// Front end: accepts input beats, classifies them and registers the work item.
`timescale 1ns / 1ps
`default_nettype none

module tohp_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tohp_item_if.sink       item,
    output logic            work_valid,
    output tohp_pkg::work_t work,
    input  wire logic       work_ready
);
    import tohp_pkg::*;

    localparam int COL_RECIP = 13;  // x*13 >> 6 equals x/5 for x below 30
    localparam int COL_SHIFT = 6;

    logic                 valid_reg;
    logic                 valid_next;
    work_t                work_reg;
    work_t                work_next;
    logic                 accept;

    logic [VALUE_W-1:0]   mag_raw;
    logic [VALUE_W-1:0]   mag_wrap;
    logic [10:0]          col_prod;
    logic [COL_IDX_W-1:0] col;
    logic [COORD_W-1:0]   slice;
    logic                 in_text;
    logic signed [11:0]   dx;
    logic [11:0]          adx;
    logic [1:0]           depth;

    assign item.ready = !valid_reg || work_ready;
    assign accept     = item.valid && item.ready;

    // Magnitude with wrap modulo 10000 (at most three subtractions apart)
    always_comb
    begin
        mag_raw = item.value_hundredths[VALUE_W-1]
                ? (~item.value_hundredths) + 16'd1
                : item.value_hundredths;
        priority if (mag_raw >= 16'(3 * MAG_MOD))
            mag_wrap = mag_raw - 16'(3 * MAG_MOD);
        else if (mag_raw >= 16'(2 * MAG_MOD))
            mag_wrap = mag_raw - 16'(2 * MAG_MOD);
        else if (mag_raw >= 16'(MAG_MOD))
            mag_wrap = mag_raw - 16'(MAG_MOD);
        else
            mag_wrap = mag_raw;
    end

    // Text cell position of the pixel
    always_comb
    begin
        col_prod = {4'b0, item.pixel_x} * 11'(COL_RECIP);
        col      = COL_IDX_W'(col_prod >> COL_SHIFT);
        slice    = item.pixel_x - 7'({4'b0, col} * 7'(CELL_PITCH));
        in_text  = (item.pixel_x < 7'(TEXT_COLS * CELL_PITCH))
                && (item.pixel_y < 7'(TEXT_ROWS * ROW_PITCH));
    end

    // Reticle V around the screen center
    always_comb
    begin
        dx    = $signed({5'b0, item.pixel_x}) - $signed(12'(SCREEN_W / 2));
        adx   = dx[11] ? 12'(-dx) : 12'(dx);
        depth = (adx >= 12'(RET_PEAK)) ? 2'd0 : 2'(12'(RET_PEAK) - adx);
    end

    // Classification
    always_comb
    begin
        work_next.is_pixel = item.kind;
        work_next.row_ok   = item.text_row < 3'(TEXT_ROWS);
        work_next.row      = item.kind ? item.pixel_y[5:3] : item.text_row;
        work_next.cidx     = item.text_colour;
        work_next.neg      = item.value_hundredths[VALUE_W-1];
        work_next.mag      = MAG_W'(mag_wrap);
        work_next.sky      = $signed({9'b0, item.pixel_y}) < item.horizon_y;
        work_next.lit_pos  = in_text
                          && (item.pixel_y[2:0] < 3'(GLYPH_H))
                          && (slice < 7'(GLYPH_W));
        work_next.col      = col;
        work_next.glyph_r  = item.pixel_y[2:0];
        work_next.glyph_s  = slice[1:0];
        work_next.reticle  = (adx <= 12'(RET_HALF))
                          && ({5'b0, item.pixel_y} == 12'(SCREEN_H / 2) + {10'b0, depth});
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (work_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= work_next;
        end
    end

    assign work_valid = valid_reg;
    assign work       = work_reg;

endmodule

`default_nettype wire

FILE: rtl/tohp_queue.sv
// Short FIFO of classified work items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module tohp_queue #(
    parameter int DEPTH = tohp_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    input  wire tohp_pkg::work_t push_work,
    output logic                 push_ready,
    output logic                 pop_valid,
    output tohp_pkg::work_t      pop_work,
    input  wire logic            pop
);
    import tohp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_work   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_work;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tohp_back.sv
// Back end: digit pipeline, text row store, glyph lookup and pixel colour output.
`timescale 1ns / 1ps
`default_nettype none

module tohp_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             work_valid,
    input  wire tohp_pkg::work_t                  work,
    output logic                                  work_pop,
    input  wire tohp_pkg::palette_t               pal,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output logic [tohp_pkg::COLOUR_W-1:0]         res_colour
);
    import tohp_pkg::*;

    // Pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic advance;

    // Stage payload
    work_t          s1_work_reg, s2_work_reg, s3_work_reg, s4_work_reg;
    logic [9:0]     s1_q1_reg;
    logic [3:0]     s2_d0_reg;
    logic [9:0]     s2_q1_reg;
    logic [6:0]     s2_q2_reg;
    logic [3:0]     s3_d0_reg;
    logic [3:0]     s3_d1_reg;
    logic [6:0]     s3_q2_reg;
    logic [3:0]     s3_q3_reg;
    logic           s4_row_written_reg;
    logic [COLOUR_W-1:0] out_colour_reg;

    // Datapath nets
    logic [26:0]    prod1;
    logic [22:0]    prod2;
    logic [19:0]    prod3;
    logic [9:0]     q1_c;
    logic [6:0]     q2_c;
    logic [3:0]     q3_c;
    logic [3:0]     d0_c;
    logic [3:0]     d1_c;
    logic [3:0]     d2_c;
    logic [CELL_W-1:0] cell0, cell1, cell2, cell3, cell4, cell5;
    logic [ROW_W-1:0]  row_wdata;
    logic [ROW_W-1:0]  row_rdata;
    logic           row_we;
    logic           row_re;
    logic [TEXT_ROWS-1:0] row_written_reg;
    logic [TEXT_ROWS-1:0] row_written_next;

    logic [CELL_W-1:0]          cell_sel;
    logic [GLYPH_W*GLYPH_H-1:0] slices;
    logic [7:0]                 slice_bits;
    logic                       lit;
    logic [COLOUR_W-1:0]        text_c;
    logic [COLOUR_W-1:0]        colour_c;

    assign advance  = !out_valid_reg || res_ready;
    assign work_pop = advance && work_valid;

    // Divide by ten through a reciprocal multiply, one digit per stage
    always_comb
    begin
        prod1 = 27'(work.mag) * 27'(RECIP10);
        q1_c  = 10'(prod1 >> RECIP_SHIFT);
        d0_c  = 4'(s1_work_reg.mag - 14'({4'b0, s1_q1_reg} * 14'(RADIX)));
        prod2 = 23'(s1_q1_reg) * 23'(RECIP10);
        q2_c  = 7'(prod2 >> RECIP_SHIFT);
        d1_c  = 4'(s2_q1_reg - 10'({3'b0, s2_q2_reg} * 10'(RADIX)));
        prod3 = 20'(s2_q2_reg) * 20'(RECIP10);
        q3_c  = 4'(prod3 >> RECIP_SHIFT);
        d2_c  = 4'(s3_q2_reg - 7'({3'b0, s3_q3_reg} * 7'(RADIX)));
    end

    // Row image: sign, two integer digits with leading blanks, dot, two fraction digits
    always_comb
    begin
        cell0 = {s3_work_reg.cidx, s3_work_reg.neg ? CODE_MINUS : CODE_BLANK};
        cell1 = {s3_work_reg.cidx, (s3_q3_reg == '0) ? CODE_BLANK : s3_q3_reg};
        cell2 = {s3_work_reg.cidx, (s3_q2_reg == '0) ? CODE_BLANK : d2_c};
        cell3 = {CIDX_DOT, CODE_DOT};
        cell4 = {s3_work_reg.cidx, s3_d1_reg};
        cell5 = {s3_work_reg.cidx, s3_d0_reg};
        row_wdata = {cell5, cell4, cell3, cell2, cell1, cell0};
    end

    assign row_we = advance && s3_valid_reg && !s3_work_reg.is_pixel && s3_work_reg.row_ok;
    assign row_re = advance && s3_valid_reg && s3_work_reg.is_pixel && s3_work_reg.lit_pos;

    tohp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TEXT_ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (s3_work_reg.row),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (s3_work_reg.row),
        .rdata (row_rdata)
    );

    // Rows never written read as blanks
    always_comb
    begin
        row_written_next = row_written_reg;
        if (row_we)
        begin
            row_written_next[s3_work_reg.row] = 1'b1;
        end
    end

    // Glyph lookup and colour choice
    always_comb
    begin
        cell_sel   = row_rdata[CELL_W * s4_work_reg.col +: CELL_W];
        slices     = glyph_slices(cell_sel[CODE_W-1:0]);
        slice_bits = {3'b0, slices[GLYPH_H * s4_work_reg.glyph_s +: GLYPH_H]};
        lit        = s4_work_reg.lit_pos && s4_row_written_reg
                  && slice_bits[s4_work_reg.glyph_r];
        unique case (cell_sel[CELL_W-1:CODE_W])
            CIDX_ZERO:  text_c = pal.text0;
            CIDX_ONE:   text_c = pal.text1;
            CIDX_TWO:   text_c = pal.text2;
            CIDX_THREE: text_c = pal.text3;
            default:    text_c = pal.text0;
        endcase
        priority if (s4_work_reg.reticle)
            colour_c = pal.reticle;
        else if (lit)
            colour_c = text_c;
        else if (s4_work_reg.sky)
            colour_c = pal.sky;
        else
            colour_c = pal.ground;
    end

    // Valid bits of the pipeline and the written-row flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            row_written_reg <= '0;
        end
        else
        begin
            row_written_reg <= row_written_next;
            if (advance)
            begin
                s1_valid_reg  <= work_valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg && s4_work_reg.is_pixel;
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_work_reg        <= work;
            s1_q1_reg          <= q1_c;
            s2_work_reg        <= s1_work_reg;
            s2_d0_reg          <= d0_c;
            s2_q1_reg          <= s1_q1_reg;
            s2_q2_reg          <= q2_c;
            s3_work_reg        <= s2_work_reg;
            s3_d0_reg          <= s2_d0_reg;
            s3_d1_reg          <= d1_c;
            s3_q2_reg          <= s2_q2_reg;
            s3_q3_reg          <= q3_c;
            s4_work_reg        <= s3_work_reg;
            s4_row_written_reg <= row_written_reg[s3_work_reg.row];
            out_colour_reg     <= colour_c;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_colour = out_colour_reg;

endmodule

`default_nettype wire

FILE: rtl/text_overlay_horizon_pixel_core.sv
// Top level: colour registers, front end, work queue and back end.
// A pixel beat passes the front register, the work queue, the back-end stages and the output register.
// Throughput: one beat per cycle, write and pixel beats alike; write beats give no result.
// A result waiting on the output register stalls the back end; the front end and the
// work queue keep accepting beats until the queue fills.
// Reset: colour registers take their defaults and all text rows read as blanks at once.
`timescale 1ns / 1ps
`default_nettype none

module text_overlay_horizon_pixel_core #(
    parameter int QUEUE_DEPTH = tohp_pkg::QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tohp_item_if.sink                            item,
    tohp_result_if.source                        result,
    input  wire logic                            wr_en,
    input  wire logic [tohp_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [tohp_pkg::COLOUR_W-1:0]   wr_data
);
    import tohp_pkg::*;

    palette_t pal_reg;
    palette_t pal_next;
    logic     front_valid;
    work_t    front_work;
    logic     front_ready;
    logic     queue_valid;
    work_t    queue_work;
    logic     queue_pop;

    // Configuration register writes; indexes past the list are ignored
    always_comb
    begin
        pal_next = pal_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_SKY:     pal_next.sky     = wr_data;
                REG_GROUND:  pal_next.ground  = wr_data;
                REG_RETICLE: pal_next.reticle = wr_data;
                REG_TEXT0:   pal_next.text0   = wr_data;
                REG_TEXT1:   pal_next.text1   = wr_data;
                REG_TEXT2:   pal_next.text2   = wr_data;
                REG_TEXT3:   pal_next.text3   = wr_data;
                default:     pal_next         = pal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_reg.sky     <= RST_SKY;
            pal_reg.ground  <= RST_GROUND;
            pal_reg.reticle <= RST_RETICLE;
            pal_reg.text0   <= RST_TEXT0;
            pal_reg.text1   <= RST_TEXT1;
            pal_reg.text2   <= RST_TEXT2;
            pal_reg.text3   <= RST_TEXT3;
        end
        else
        begin
            pal_reg <= pal_next;
        end
    end

    tohp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .work_valid (front_valid),
        .work       (front_work),
        .work_ready (front_ready)
    );

    tohp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_work  (front_work),
        .push_ready (front_ready),
        .pop_valid  (queue_valid),
        .pop_work   (queue_work),
        .pop        (queue_pop)
    );

    tohp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (queue_valid),
        .work       (queue_work),
        .work_pop   (queue_pop),
        .pal        (pal_reg),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .res_colour (result.pixel_colour)
    );

endmodule

`default_nettype wire

FILE: sim/text_overlay_horizon_pixel_core_tb.sv
// Self-checking testbench of the text overlay horizon pixel core: predicted pixel colours vs. output.
`timescale 1ns / 1ps

module text_overlay_horizon_pixel_core_tb;
    import tohp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 12;     // settling margin after the last expected pixel
    localparam int HOLD_CYCLES  = 150;    // long output stall for the fill test
    localparam int PHASE_BEATS  = 300;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NONE   = 3'd7;   // unmapped register index
    localparam logic [ROW_IDX_W-1:0] ROW_ABSENT = 3'd7;   // text row past the store

    typedef struct packed {
        logic                kind;
        logic [2:0]          text_row;
        logic [1:0]          text_colour;
        logic signed [15:0]  value;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic signed [15:0]  horizon;
    } overlay_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [COLOUR_W-1:0]   wr_data;

    tohp_item_if   item_ch ();
    tohp_result_if result_ch ();

    text_overlay_horizon_pixel_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Predictor state: colour registers and the character store
    logic [COLOUR_W-1:0] colour_reg [TEXT_ROWS];
    logic [CELL_W-1:0]   text_cells [TEXT_ROWS*TEXT_COLS];
    logic [COLOUR_W-1:0] pixel_expect [$];
    logic [COLOUR_W-1:0] colour_want;

    int fail_count;
    bit no_idle;
    bit hold_req;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Font columns of one code, slice 0 in the top five bits, bit r = glyph row r
    function automatic logic [19:0] font_of(input logic [CODE_W-1:0] code);
        case (code)
            4'd0:       return {5'h0E, 5'h11, 5'h11, 5'h0E};
            4'd1:       return {5'h12, 5'h1F, 5'h10, 5'h00};
            4'd2:       return {5'h12, 5'h19, 5'h15, 5'h12};
            4'd3:       return {5'h11, 5'h11, 5'h15, 5'h0A};
            4'd4:       return {5'h07, 5'h04, 5'h1F, 5'h04};
            4'd5:       return {5'h17, 5'h15, 5'h15, 5'h09};
            4'd6:       return {5'h0E, 5'h15, 5'h15, 5'h09};
            4'd7:       return {5'h11, 5'h09, 5'h05, 5'h03};
            4'd8:       return {5'h0A, 5'h15, 5'h15, 5'h0A};
            4'd9:       return {5'h02, 5'h05, 5'h15, 5'h0E};
            CODE_MINUS: return {5'h04, 5'h04, 5'h04, 5'h04};
            CODE_DOT:   return {5'h00, 5'h10, 5'h10, 5'h00};
            default:    return 20'h0;
        endcase
    endfunction

    function automatic void reset_model();
        colour_reg[REG_SKY]     = RST_SKY;
        colour_reg[REG_GROUND]  = RST_GROUND;
        colour_reg[REG_RETICLE] = RST_RETICLE;
        colour_reg[REG_TEXT0]   = RST_TEXT0;
        colour_reg[REG_TEXT1]   = RST_TEXT1;
        colour_reg[REG_TEXT2]   = RST_TEXT2;
        colour_reg[REG_TEXT3]   = RST_TEXT3;
        for (int i = 0; i < TEXT_ROWS*TEXT_COLS; i++)
            text_cells[i] = {CIDX_ZERO, CODE_BLANK};
    endfunction

    // Format a hundredths value into one text row: sign, two digits, dot, two digits
    function automatic void store_row(input logic [2:0] row, input logic [1:0] cidx,
                                      input logic [15:0] value);
        int               mag;
        int               base;
        logic             neg;
        logic [CODE_W-1:0] digit;
        neg = value[15];
        mag = neg ? 65536 - int'({16'h0, value}) : int'({16'h0, value});
        if (row >= TEXT_ROWS)
            return;
        if (mag >= MAG_MOD)
            mag = mag % MAG_MOD;
        base = row * TEXT_COLS;
        text_cells[base] = {cidx, neg ? CODE_MINUS : CODE_BLANK};
        digit = CODE_W'(mag % RADIX);
        text_cells[base + 5] = {cidx, digit};
        mag = mag / RADIX;
        digit = CODE_W'(mag % RADIX);
        text_cells[base + 4] = {cidx, digit};
        mag = mag / RADIX;
        text_cells[base + 3] = {CIDX_DOT, CODE_DOT};
        digit = CODE_W'(mag % RADIX);
        text_cells[base + 2] = {cidx, (mag == 0) ? CODE_BLANK : digit};
        mag = mag / RADIX;
        digit = CODE_W'(mag % RADIX);
        text_cells[base + 1] = {cidx, (mag == 0) ? CODE_BLANK : digit};
    endfunction

    // Colour of one pixel: sky/ground split, glyph overlay, then the reticle
    function automatic logic [COLOUR_W-1:0] expected_colour(input logic [COORD_W-1:0] x,
                                                            input logic [COORD_W-1:0] y,
                                                            input logic signed [15:0] horizon);
        int                  xi, yi, hi;
        int                  row, r, col, s;
        int                  dx, ad, depth;
        logic [CELL_W-1:0]   store_word;
        logic [19:0]         font;
        logic [COLOUR_W-1:0] c;
        xi = int'(x);
        yi = int'(y);
        hi = int'(horizon);
        c = (yi < hi) ? colour_reg[REG_SKY] : colour_reg[REG_GROUND];
        if (xi < TEXT_COLS*CELL_PITCH && yi < TEXT_ROWS*ROW_PITCH)
        begin
            row  = yi / ROW_PITCH;
            r    = yi % ROW_PITCH;
            col  = xi / CELL_PITCH;
            s    = xi % CELL_PITCH;
            store_word = text_cells[row*TEXT_COLS + col];
            font = font_of(store_word[CODE_W-1:0]);
            if (r < GLYPH_H && s < GLYPH_W && store_word[CODE_W-1:0] <= CODE_DOT
                && font[(3 - s)*GLYPH_H + r])
                c = colour_reg[int'(REG_TEXT0) + store_word[CELL_W-1:CODE_W]];
        end
        dx = xi - SCREEN_W/2;
        ad = (dx < 0) ? -dx : dx;
        if (ad <= RET_HALF)
        begin
            depth = RET_PEAK - ad;
            if (depth < 0)
                depth = 0;
            if (yi == SCREEN_H/2 + depth)
                c = colour_reg[REG_RETICLE];
        end
        return c;
    endfunction

    function automatic overlay_beat_t pixel_beat(input int x, input int y, input int h);
        overlay_beat_t b;
        b = '0;
        b.kind    = KIND_PIXEL;
        b.x       = COORD_W'(x);
        b.y       = COORD_W'(y);
        b.horizon = 16'(h);
        return b;
    endfunction

    function automatic overlay_beat_t write_beat(input logic [2:0] row, input logic [1:0] cidx,
                                                 input int value);
        overlay_beat_t b;
        b = '0;
        b.kind        = KIND_WRITE;
        b.text_row    = row;
        b.text_colour = cidx;
        b.value       = 16'(value);
        return b;
    endfunction

    // Random beat, biased toward the text area, the reticle and the horizon edge
    function automatic overlay_beat_t random_beat();
        overlay_beat_t b;
        int            sel;
        b.kind        = ($urandom_range(0, 3) != 0) ? KIND_PIXEL : KIND_WRITE;
        b.text_row    = ($urandom_range(0, 15) == 0) ? ROW_ABSENT : 3'($urandom_range(0, 6));
        b.text_colour = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 3);
        case (sel)
            0: b.value = 16'($urandom);
            1: b.value = 16'($urandom_range(0, 19998) - 9999);
            2: b.value = 16'($urandom_range(0, 198) - 99);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: b.value = 16'sh7FFF;
                    1: b.value = 16'sh8000;
                    2: b.value = 16'sh8001;
                    3: b.value = 16'sd10000;
                    default: b.value = -16'sd10000;
                endcase
            end
        endcase
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            b.x = COORD_W'($urandom_range(0, TEXT_COLS*CELL_PITCH - 1));
            b.y = COORD_W'($urandom_range(0, TEXT_ROWS*ROW_PITCH - 1));
        end
        else if (sel < 6)
        begin
            b.x = COORD_W'($urandom_range(SCREEN_W/2 - RET_HALF - 2,
                                          SCREEN_W/2 + RET_HALF + 2));
            b.y = COORD_W'($urandom_range(SCREEN_H/2 - 2, SCREEN_H/2 + RET_PEAK + 1));
        end
        else
        begin
            b.x = COORD_W'($urandom);
            b.y = COORD_W'($urandom);
        end
        case ($urandom_range(0, 3))
            0: b.horizon = 16'($urandom);
            1: b.horizon = 16'(int'(b.y) + $urandom_range(0, 4) - 2);
            2: b.horizon = 16'($urandom_range(0, SCREEN_H - 1));
            default: b.horizon = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
        return b;
    endfunction

    // Offer one beat, sometimes after a random idle gap; valid stays high afterwards
    task automatic send_beat(input overlay_beat_t b);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.kind             <= b.kind;
        item_ch.text_row         <= b.text_row;
        item_ch.text_colour      <= b.text_colour;
        item_ch.value_hundredths <= b.value;
        item_ch.pixel_x          <= b.x;
        item_ch.pixel_y          <= b.y;
        item_ch.horizon_y        <= b.horizon;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (b.kind == KIND_WRITE)
            store_row(b.text_row, b.text_colour, b.value);
        else
            pixel_expect.push_back(expected_colour(b.x, b.y, b.horizon));
    endtask

    // Drop valid, wait for every expected pixel, then let write beats settle
    task automatic wait_drain();
        item_ch.valid <= 1'b0;
        while (pixel_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all seven colour registers, plus one write to the unmapped index
    task automatic write_palette(input logic [15:0] sky, input logic [15:0] ground,
                                 input logic [15:0] ret, input logic [15:0] t0,
                                 input logic [15:0] t1, input logic [15:0] t2,
                                 input logic [15:0] t3);
        logic [COLOUR_W-1:0] vals [TEXT_ROWS];
        vals[REG_SKY]     = sky;
        vals[REG_GROUND]  = ground;
        vals[REG_RETICLE] = ret;
        vals[REG_TEXT0]   = t0;
        vals[REG_TEXT1]   = t1;
        vals[REG_TEXT2]   = t2;
        vals[REG_TEXT3]   = t3;
        for (int i = REG_SKY; i <= REG_TEXT3; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= CFG_IDX_W'(i);
            wr_data  <= vals[i];
            @(posedge clk);
            colour_reg[i] = vals[i];
        end
        wr_index <= REG_NONE;
        wr_data  <= COLOUR_W'($urandom);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Reset palette: sky, ground, reticle and blank text, horizon extremes
    task automatic test_reset_defaults();
        send_beat(pixel_beat(10, 100, 50));
        send_beat(pixel_beat(10, 20, 50));
        send_beat(pixel_beat(SCREEN_W/2, SCREEN_H/2 + RET_PEAK, 0));
        send_beat(pixel_beat(SCREEN_W/2 - RET_HALF, SCREEN_H/2, -32768));
        send_beat(pixel_beat(0, 0, 32767));
        send_beat(pixel_beat(127, 127, -32768));
        wait_drain();
    endtask

    // Number formatting: extremes, wrap, minus, dot colour, ignored row
    task automatic test_number_format();
        send_beat(write_beat(0, CIDX_THREE, 32767));
        send_beat(write_beat(1, CIDX_ONE, -32768));
        send_beat(write_beat(2, CIDX_TWO, 0));
        send_beat(write_beat(3, CIDX_ZERO, 9999));
        send_beat(write_beat(4, CIDX_ONE, -1));
        send_beat(write_beat(5, CIDX_TWO, 10000));
        send_beat(write_beat(6, CIDX_TWO, -9999));
        send_beat(write_beat(ROW_ABSENT, CIDX_THREE, 1234));
        send_beat(pixel_beat(0, 10, 0));     // minus sign
        send_beat(pixel_beat(5, 1, 0));      // leading digit
        send_beat(pixel_beat(16, 4, 0));     // dot, always colour zero
        send_beat(pixel_beat(3, 0, 0));      // blank sign cell
        send_beat(pixel_beat(4, 2, 0));      // gap column
        send_beat(pixel_beat(0, 13, 0));     // gap row
        send_beat(pixel_beat(25, 41, 0));    // wrapped to zero
        send_beat(pixel_beat(5, 49, 127));   // last row
        wait_drain();
    endtask

    task automatic run_random(input int count);
        repeat (count) send_beat(random_beat());
    endtask

    // Random traffic under several palettes, extremes among them
    task automatic test_palette_sweeps();
        write_palette(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(PHASE_BEATS);
        wait_drain();
        write_palette(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(PHASE_BEATS);
        wait_drain();
        write_palette(16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0F0F);
        run_random(PHASE_BEATS);
        wait_drain();
        write_palette(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
        run_random(PHASE_BEATS);
        wait_drain();
        write_palette(RST_SKY, RST_GROUND, RST_RETICLE, RST_TEXT0, RST_TEXT1, RST_TEXT2,
                      RST_TEXT3);
        run_random(150);
    endtask

    // Long output stall while pixel beats keep coming, so the input stalls
    task automatic test_output_hold();
        overlay_beat_t b;
        hold_req = 1'b1;
        repeat (80)
        begin
            b = random_beat();
            b.kind = KIND_PIXEL;
            send_beat(b);
        end
    endtask

    // Back-to-back beats, no idling on either side
    task automatic test_steady_stream();
        no_idle = 1'b1;
        run_random(400);
    endtask

    // Output ready: random stall bursts, one long hold on request
    initial
    begin : result_ready_drive
        int stall;
        result_ch.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall = stall - 1;
                result_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                stall = int'($urandom_range(1, 15)) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expected colour
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pixel_expect.size() == 0)
            begin
                $display("%0t: unexpected pixel beat, expected none, actual %h",
                         $time, result_ch.pixel_colour);
                fail_count++;
            end
            else
            begin
                colour_want = pixel_expect.pop_front();
                if (result_ch.pixel_colour !== colour_want)
                begin
                    $display("%0t: pixel_colour mismatch, expected %h, actual %h",
                             $time, colour_want, result_ch.pixel_colour);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Test sequence
    initial
    begin
        rst_n                    = 1'b0;
        wr_en                    = 1'b0;
        wr_index                 = REG_SKY;
        wr_data                  = '0;
        item_ch.valid            = 1'b0;
        item_ch.kind             = KIND_WRITE;
        item_ch.text_row         = '0;
        item_ch.text_colour      = CIDX_ZERO;
        item_ch.value_hundredths = '0;
        item_ch.pixel_x          = '0;
        item_ch.pixel_y          = '0;
        item_ch.horizon_y        = '0;
        fail_count               = 0;
        no_idle                  = 1'b0;
        hold_req                 = 1'b0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_number_format();
        test_palette_sweeps();
        test_output_hold();
        test_steady_stream();
        wait_drain();

        if (fail_count == 0 && pixel_expect.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tohp_pkg.sv
rtl/tohp_if.sv
rtl/tohp_ram.sv
rtl/tohp_front.sv
rtl/tohp_queue.sv
rtl/tohp_back.sv
rtl/text_overlay_horizon_pixel_core.sv
sim/text_overlay_horizon_pixel_core_tb.sv
